>>> src/mpwpag_pkg.sv
// Shared constants and types for the multipass window patch address generator.
package mpwpag_pkg;

    localparam int MAX_IMAGE_DIM = 1024;
    localparam int MAX_WINDOW    = 32;
    localparam int MAX_CHANNELS  = 4;
    localparam int MAX_PASSES    = 16;

    localparam int IMG_W      = 11;  // image_rows / image_cols register width
    localparam int CH_W       = 3;
    localparam int WIN_W      = 6;
    localparam int PASSCFG_W  = 5;
    localparam int SHIFT_W    = 10;
    localparam int PASS_W     = 4;
    localparam int PLANE_W    = 2;
    localparam int TILE_W     = 10;
    localparam int WCNT_W     = 5;
    localparam int POS_W      = 16;  // shifted pixel row/column position
    localparam int SRC_W      = 22;
    localparam int DST_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_SHIFT    = 3'd5;

    // run constants worked out once per restart
    typedef struct packed {
        logic [IMG_W-1:0]     rows;
        logic [IMG_W-1:0]     cols;
        logic [CH_W-1:0]      ch;
        logic [WIN_W-1:0]     win;
        logic [PASSCFG_W-1:0] passes;
        logic [SHIFT_W-1:0]   shift;
        logic [IMG_W-1:0]     tr;
        logic [IMG_W-1:0]     tc;
        logic [DST_W-1:0]     tile_a;     // windows in pass 0
        logic [DST_W-1:0]     tile_b;     // windows in each later pass
        logic [DST_W-1:0]     ort;        // output row total
        logic [DST_W-1:0]     ort_w;      // ort * W
        logic [DST_W-1:0]     ort_w2;     // ort * W * W
        logic [SRC_W-1:0]     plane_lin;  // rows * cols
        logic [SRC_W-1:0]     shift_lin;  // shift * rows
        logic [SRC_W-1:0]     win_lin;    // W * rows
        logic                 ok;
    } run_params_t;

    typedef struct packed {
        logic              pair_valid;
        logic [SRC_W-1:0]  source_address;
        logic [DST_W-1:0]  dest_address;
        logic [PASS_W-1:0] pass_number;
        logic              outside_image;
        logic              last_pair;
    } step_result_t;

endpackage

>>> src/mpwpag_setup.sv
// Restart setup: saturates the config, divides out tile counts, forms run constants.
module mpwpag_setup (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            launch,
    input  logic [mpwpag_pkg::IMG_W-1:0]     cfg_rows,
    input  logic [mpwpag_pkg::IMG_W-1:0]     cfg_cols,
    input  logic [mpwpag_pkg::CH_W-1:0]      cfg_ch,
    input  logic [mpwpag_pkg::WIN_W-1:0]     cfg_win,
    input  logic [mpwpag_pkg::PASSCFG_W-1:0] cfg_passes,
    input  logic [mpwpag_pkg::SHIFT_W-1:0]   cfg_shift,
    output mpwpag_pkg::run_params_t         params,
    output logic                            busy,
    output logic                            start
);
    import mpwpag_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_MUL3 = 3'd4;
    localparam logic [2:0] ST_MUL4 = 3'd5;
    localparam logic [2:0] ST_ARM  = 3'd6;

    localparam logic [3:0] DIV_LAST = 4'(IMG_W - 1);

    logic [2:0]           state_reg, state_next;
    logic [3:0]           step_reg, step_next;

    logic [IMG_W-1:0]     rows_reg, cols_reg;
    logic [CH_W-1:0]      ch_reg;
    logic [WIN_W-1:0]     win_reg;
    logic [PASSCFG_W-1:0] passes_reg;
    logic [SHIFT_W-1:0]   shift_reg;
    logic [IMG_W-1:0]     num_r_reg, num_c_reg, q_r_reg, q_c_reg;
    logic [WIN_W-1:0]     rem_r_reg, rem_c_reg;
    logic [IMG_W-1:0]     tr_reg, tc_reg;
    logic [DST_W-1:0]     tile_a_reg, tile_b_reg, ort_reg, ort_w_reg, ort_w2_reg;
    logic [SRC_W-1:0]     plane_lin_reg, shift_lin_reg, win_lin_reg;
    logic                 ok_reg;

    // saturated config
    logic [IMG_W-1:0]     rows_sat, cols_sat;
    logic [CH_W-1:0]      ch_sat;
    logic [WIN_W-1:0]     win_sat;
    logic [PASSCFG_W-1:0] passes_sat;

    // divider step
    logic [WIN_W:0]       trial_r, trial_c, diff_r, diff_c;
    logic                 ge_r, ge_c;

    // first multiply stage
    logic [IMG_W-1:0]     tr_eff, tc_eff, tr_m1, tc_m1;
    logic [2*IMG_W-1:0]   prod_a, prod_b, prod_plane;
    logic                 few_tiles;

    always_comb
    begin
        rows_sat   = (cfg_rows > IMG_W'(MAX_IMAGE_DIM)) ? IMG_W'(MAX_IMAGE_DIM) : cfg_rows;
        cols_sat   = (cfg_cols > IMG_W'(MAX_IMAGE_DIM)) ? IMG_W'(MAX_IMAGE_DIM) : cfg_cols;
        ch_sat     = (cfg_ch > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : cfg_ch;
        win_sat    = (cfg_win > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : cfg_win;
        if (cfg_passes == '0)
            passes_sat = PASSCFG_W'(1);
        else if (cfg_passes > PASSCFG_W'(MAX_PASSES))
            passes_sat = PASSCFG_W'(MAX_PASSES);
        else
            passes_sat = cfg_passes;
    end

    // restoring division, one quotient bit per cycle for both axes
    always_comb
    begin
        trial_r = {rem_r_reg, num_r_reg[IMG_W-1]};
        trial_c = {rem_c_reg, num_c_reg[IMG_W-1]};
        ge_r    = trial_r >= {1'b0, win_reg};
        ge_c    = trial_c >= {1'b0, win_reg};
        diff_r  = ge_r ? (trial_r - {1'b0, win_reg}) : trial_r;
        diff_c  = ge_c ? (trial_c - {1'b0, win_reg}) : trial_c;
    end

    always_comb
    begin
        tr_eff     = (win_reg == '0) ? '0 : q_r_reg;
        tc_eff     = (win_reg == '0) ? '0 : q_c_reg;
        tr_m1      = tr_eff - IMG_W'(1);
        tc_m1      = tc_eff - IMG_W'(1);
        prod_a     = (2*IMG_W)'(tr_eff) * (2*IMG_W)'(tc_eff);
        prod_b     = (2*IMG_W)'(tr_m1) * (2*IMG_W)'(tc_m1);
        prod_plane = (2*IMG_W)'(rows_reg) * (2*IMG_W)'(cols_reg);
        few_tiles  = (tr_eff < IMG_W'(2)) || (tc_eff < IMG_W'(2));
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (launch)
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == DIV_LAST)
                    state_next = ST_MUL1;
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_MUL4;
            ST_MUL4: state_next = ST_ARM;
            ST_ARM:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch && (state_reg == ST_IDLE))
        begin
            rows_reg   <= rows_sat;
            cols_reg   <= cols_sat;
            ch_reg     <= ch_sat;
            win_reg    <= win_sat;
            passes_reg <= passes_sat;
            shift_reg  <= cfg_shift;
            num_r_reg  <= rows_sat;
            num_c_reg  <= cols_sat;
            rem_r_reg  <= '0;
            rem_c_reg  <= '0;
            q_r_reg    <= '0;
            q_c_reg    <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            num_r_reg <= {num_r_reg[IMG_W-2:0], 1'b0};
            num_c_reg <= {num_c_reg[IMG_W-2:0], 1'b0};
            rem_r_reg <= diff_r[WIN_W-1:0];
            rem_c_reg <= diff_c[WIN_W-1:0];
            q_r_reg   <= {q_r_reg[IMG_W-2:0], ge_r};
            q_c_reg   <= {q_c_reg[IMG_W-2:0], ge_c};
        end
        if (state_reg == ST_MUL1)
        begin
            tr_reg        <= tr_eff;
            tc_reg        <= tc_eff;
            tile_a_reg    <= DST_W'(prod_a);
            tile_b_reg    <= DST_W'(prod_b);
            plane_lin_reg <= SRC_W'(prod_plane);
            shift_lin_reg <= SRC_W'(shift_reg) * SRC_W'(rows_reg);
            win_lin_reg   <= SRC_W'(win_reg) * SRC_W'(rows_reg);
            ok_reg        <= (tr_eff != '0) && (tc_eff != '0) && (ch_reg != '0);
            if (few_tiles)
                passes_reg <= PASSCFG_W'(1);
        end
        if (state_reg == ST_MUL2)
            ort_reg <= tile_a_reg + DST_W'(passes_reg - PASSCFG_W'(1)) * tile_b_reg;
        if (state_reg == ST_MUL3)
            ort_w_reg <= ort_reg * DST_W'(win_reg);
        if (state_reg == ST_MUL4)
            ort_w2_reg <= ort_w_reg * DST_W'(win_reg);
    end

    assign busy  = (state_reg != ST_IDLE);
    assign start = (state_reg == ST_ARM);

    always_comb
    begin
        params.rows      = rows_reg;
        params.cols      = cols_reg;
        params.ch        = ch_reg;
        params.win       = win_reg;
        params.passes    = passes_reg;
        params.shift     = shift_reg;
        params.tr        = tr_reg;
        params.tc        = tc_reg;
        params.tile_a    = tile_a_reg;
        params.tile_b    = tile_b_reg;
        params.ort       = ort_reg;
        params.ort_w     = ort_w_reg;
        params.ort_w2    = ort_w2_reg;
        params.plane_lin = plane_lin_reg;
        params.shift_lin = shift_lin_reg;
        params.win_lin   = win_lin_reg;
        params.ok        = ok_reg;
    end

endmodule

>>> src/mpwpag_walker.sv
// Nested loop counters with incrementally updated source/destination addresses.
module mpwpag_walker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      start,
    input  logic                      step,
    input  mpwpag_pkg::run_params_t   params,
    output mpwpag_pkg::step_result_t  result
);
    import mpwpag_pkg::*;

    logic                run_active_reg, run_active_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic [PLANE_W-1:0]  plane_reg, plane_next;
    logic [TILE_W-1:0]   tile_row_reg, tile_row_next;
    logic [TILE_W-1:0]   tile_col_reg, tile_col_next;
    logic [WCNT_W-1:0]   win_col_reg, win_col_next;
    logic [WCNT_W-1:0]   win_row_reg, win_row_next;
    logic [DST_W-1:0]    wri_reg, wri_next;
    logic [DST_W-1:0]    pass_base_reg, pass_base_next;
    logic [SRC_W-1:0]    source_base_reg, source_base_next;
    logic [POS_W-1:0]    off_reg, off_next;
    logic [SRC_W-1:0]    off_lin_reg, off_lin_next;
    logic [POS_W-1:0]    tile_row_pos_reg, tile_row_pos_next;
    logic [POS_W-1:0]    row_pos_reg, row_pos_next;
    logic [POS_W-1:0]    tile_col_pos_reg, tile_col_pos_next;
    logic [POS_W-1:0]    col_pos_reg, col_pos_next;
    logic [SRC_W-1:0]    tile_col_lin_reg, tile_col_lin_next;
    logic [SRC_W-1:0]    col_lin_reg, col_lin_next;
    logic [DST_W-1:0]    dest_plane_reg, dest_plane_next;
    logic [DST_W-1:0]    dest_col_reg, dest_col_next;
    logic [DST_W-1:0]    dest_off_reg, dest_off_next;

    logic [WIN_W-1:0]    win_m1;
    logic [IMG_W-1:0]    tr_last, tc_last;
    logic                wr_wrap, wc_wrap, tc_wrap, tr_wrap, pl_wrap, ps_wrap;
    logic                outside;
    logic [POS_W-1:0]    win_pos;

    always_comb
    begin
        win_m1  = params.win - WIN_W'(1);
        win_pos = POS_W'(params.win);
        tr_last = (pass_reg == '0) ? (params.tr - IMG_W'(1)) : (params.tr - IMG_W'(2));
        tc_last = (pass_reg == '0) ? (params.tc - IMG_W'(1)) : (params.tc - IMG_W'(2));
        wr_wrap = {1'b0, win_row_reg} == win_m1;
        wc_wrap = {1'b0, win_col_reg} == win_m1;
        tc_wrap = {1'b0, tile_col_reg} == tc_last;
        tr_wrap = {1'b0, tile_row_reg} == tr_last;
        pl_wrap = {1'b0, plane_reg} == (params.ch - CH_W'(1));
        ps_wrap = {1'b0, pass_reg} == (params.passes - PASSCFG_W'(1));
        outside = (row_pos_reg >= POS_W'(params.rows)) || (col_pos_reg >= POS_W'(params.cols));
    end

    always_comb
    begin
        result = '0;
        if (run_active_reg)
        begin
            result.pair_valid     = 1'b1;
            result.source_address = outside ? '0 :
                                    (source_base_reg + col_lin_reg + SRC_W'(row_pos_reg));
            result.dest_address   = wri_reg + dest_off_reg;
            result.pass_number    = pass_reg;
            result.outside_image  = outside;
            result.last_pair      = wr_wrap && wc_wrap && tc_wrap && tr_wrap
                                    && pl_wrap && ps_wrap;
        end
    end

    always_comb
    begin
        run_active_next   = run_active_reg;
        pass_next         = pass_reg;
        plane_next        = plane_reg;
        tile_row_next     = tile_row_reg;
        tile_col_next     = tile_col_reg;
        win_col_next      = win_col_reg;
        win_row_next      = win_row_reg;
        wri_next          = wri_reg;
        pass_base_next    = pass_base_reg;
        source_base_next  = source_base_reg;
        off_next          = off_reg;
        off_lin_next      = off_lin_reg;
        tile_row_pos_next = tile_row_pos_reg;
        row_pos_next      = row_pos_reg;
        tile_col_pos_next = tile_col_pos_reg;
        col_pos_next      = col_pos_reg;
        tile_col_lin_next = tile_col_lin_reg;
        col_lin_next      = col_lin_reg;
        dest_plane_next   = dest_plane_reg;
        dest_col_next     = dest_col_reg;
        dest_off_next     = dest_off_reg;

        if (clear)
        begin
            run_active_next   = 1'b0;
            pass_next         = '0;
            plane_next        = '0;
            tile_row_next     = '0;
            tile_col_next     = '0;
            win_col_next      = '0;
            win_row_next      = '0;
            wri_next          = '0;
            pass_base_next    = '0;
            source_base_next  = '0;
            off_next          = '0;
            off_lin_next      = '0;
            tile_row_pos_next = '0;
            row_pos_next      = '0;
            tile_col_pos_next = '0;
            col_pos_next      = '0;
            tile_col_lin_next = '0;
            col_lin_next      = '0;
            dest_plane_next   = '0;
            dest_col_next     = '0;
            dest_off_next     = '0;
        end
        else if (start)
        begin
            run_active_next = params.ok;
        end
        else if (step && run_active_reg)
        begin
            if (!wr_wrap)
            begin
                win_row_next  = win_row_reg + WCNT_W'(1);
                row_pos_next  = row_pos_reg + POS_W'(1);
                dest_off_next = dest_off_reg + params.ort;
            end
            else if (!wc_wrap)
            begin
                win_row_next  = '0;
                win_col_next  = win_col_reg + WCNT_W'(1);
                row_pos_next  = tile_row_pos_reg;
                col_pos_next  = col_pos_reg + POS_W'(1);
                col_lin_next  = col_lin_reg + SRC_W'(params.rows);
                dest_col_next = dest_col_reg + params.ort_w;
                dest_off_next = dest_col_reg + params.ort_w;
            end
            else if (!tc_wrap)
            begin
                win_row_next      = '0;
                win_col_next      = '0;
                tile_col_next     = tile_col_reg + TILE_W'(1);
                row_pos_next      = tile_row_pos_reg;
                tile_col_pos_next = tile_col_pos_reg + win_pos;
                col_pos_next      = tile_col_pos_reg + win_pos;
                tile_col_lin_next = tile_col_lin_reg + params.win_lin;
                col_lin_next      = tile_col_lin_reg + params.win_lin;
                dest_col_next     = dest_plane_reg;
                dest_off_next     = dest_plane_reg;
                wri_next          = wri_reg + DST_W'(1);
            end
            else if (!tr_wrap)
            begin
                win_row_next      = '0;
                win_col_next      = '0;
                tile_col_next     = '0;
                tile_row_next     = tile_row_reg + TILE_W'(1);
                tile_row_pos_next = tile_row_pos_reg + win_pos;
                row_pos_next      = tile_row_pos_reg + win_pos;
                tile_col_pos_next = off_reg;
                col_pos_next      = off_reg;
                tile_col_lin_next = off_lin_reg;
                col_lin_next      = off_lin_reg;
                dest_col_next     = dest_plane_reg;
                dest_off_next     = dest_plane_reg;
                wri_next          = wri_reg + DST_W'(1);
            end
            else if (!pl_wrap)
            begin
                win_row_next      = '0;
                win_col_next      = '0;
                tile_col_next     = '0;
                tile_row_next     = '0;
                plane_next        = plane_reg + PLANE_W'(1);
                tile_row_pos_next = off_reg;
                row_pos_next      = off_reg;
                tile_col_pos_next = off_reg;
                col_pos_next      = off_reg;
                tile_col_lin_next = off_lin_reg;
                col_lin_next      = off_lin_reg;
                source_base_next  = source_base_reg + params.plane_lin;
                dest_plane_next   = dest_plane_reg + params.ort_w2;
                dest_col_next     = dest_plane_reg + params.ort_w2;
                dest_off_next     = dest_plane_reg + params.ort_w2;
                wri_next          = pass_base_reg;
            end
            else if (!ps_wrap)
            begin
                win_row_next      = '0;
                win_col_next      = '0;
                tile_col_next     = '0;
                tile_row_next     = '0;
                plane_next        = '0;
                pass_next         = pass_reg + PASS_W'(1);
                off_next          = off_reg + POS_W'(params.shift);
                off_lin_next      = off_lin_reg + params.shift_lin;
                tile_row_pos_next = off_reg + POS_W'(params.shift);
                row_pos_next      = off_reg + POS_W'(params.shift);
                tile_col_pos_next = off_reg + POS_W'(params.shift);
                col_pos_next      = off_reg + POS_W'(params.shift);
                tile_col_lin_next = off_lin_reg + params.shift_lin;
                col_lin_next      = off_lin_reg + params.shift_lin;
                source_base_next  = '0;
                dest_plane_next   = '0;
                dest_col_next     = '0;
                dest_off_next     = '0;
                // pass 0 has the full tile grid, later passes one row and column fewer
                pass_base_next    = pass_base_reg
                                    + ((pass_reg == '0) ? params.tile_a : params.tile_b);
                wri_next          = pass_base_reg
                                    + ((pass_reg == '0) ? params.tile_a : params.tile_b);
            end
            else
            begin
                run_active_next = 1'b0;
                win_row_next    = '0;
                win_col_next    = '0;
                tile_col_next   = '0;
                tile_row_next   = '0;
                plane_next      = '0;
                pass_next       = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg   <= 1'b0;
            pass_reg         <= '0;
            plane_reg        <= '0;
            tile_row_reg     <= '0;
            tile_col_reg     <= '0;
            win_col_reg      <= '0;
            win_row_reg      <= '0;
            wri_reg          <= '0;
            pass_base_reg    <= '0;
            source_base_reg  <= '0;
            off_reg          <= '0;
            off_lin_reg      <= '0;
            tile_row_pos_reg <= '0;
            row_pos_reg      <= '0;
            tile_col_pos_reg <= '0;
            col_pos_reg      <= '0;
            tile_col_lin_reg <= '0;
            col_lin_reg      <= '0;
            dest_plane_reg   <= '0;
            dest_col_reg     <= '0;
            dest_off_reg     <= '0;
        end
        else
        begin
            run_active_reg   <= run_active_next;
            pass_reg         <= pass_next;
            plane_reg        <= plane_next;
            tile_row_reg     <= tile_row_next;
            tile_col_reg     <= tile_col_next;
            win_col_reg      <= win_col_next;
            win_row_reg      <= win_row_next;
            wri_reg          <= wri_next;
            pass_base_reg    <= pass_base_next;
            source_base_reg  <= source_base_next;
            off_reg          <= off_next;
            off_lin_reg      <= off_lin_next;
            tile_row_pos_reg <= tile_row_pos_next;
            row_pos_reg      <= row_pos_next;
            tile_col_pos_reg <= tile_col_pos_next;
            col_pos_reg      <= col_pos_next;
            tile_col_lin_reg <= tile_col_lin_next;
            col_lin_reg      <= col_lin_next;
            dest_plane_reg   <= dest_plane_next;
            dest_col_reg     <= dest_col_next;
            dest_off_reg     <= dest_off_next;
        end
    end

endmodule

>>> src/multipass_window_patch_address_gen.sv
// Top level: config registers, handshake, result register.
// An advance transaction (restart 0) is registered at the output in the cycle after acceptance;
// advance transactions are taken every cycle while the output is drained.
// A restart transaction runs the setup unit (11-step tile divider, four multiply steps, arm)
// and its first pair is registered once the setup unit is idle again; no input is taken meanwhile.
// Reset (rst_n low, asynchronous) restores config defaults and leaves no run active.
module multipass_window_patch_address_gen (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mpwpag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpwpag_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             pair_valid,
    output logic [mpwpag_pkg::SRC_W-1:0]      source_address,
    output logic [mpwpag_pkg::DST_W-1:0]      dest_address,
    output logic [mpwpag_pkg::PASS_W-1:0]     pass_number,
    output logic                             outside_image,
    output logic                             last_pair
);
    import mpwpag_pkg::*;

    logic [IMG_W-1:0]     image_rows_reg, image_cols_reg;
    logic [CH_W-1:0]      channel_count_reg;
    logic [WIN_W-1:0]     window_size_reg;
    logic [PASSCFG_W-1:0] pass_count_reg;
    logic [SHIFT_W-1:0]   pass_shift_reg;

    logic                 first_pending_reg, first_pending_next;
    logic                 out_valid_reg, out_valid_next;
    step_result_t         result_reg;

    logic                 in_accept, launch, step_fire;
    logic                 setup_busy, setup_start;
    run_params_t          params;
    step_result_t         step_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg    <= IMG_W'(64);
            image_cols_reg    <= IMG_W'(64);
            channel_count_reg <= CH_W'(1);
            window_size_reg   <= WIN_W'(8);
            pass_count_reg    <= PASSCFG_W'(1);
            pass_shift_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_ROWS:    image_rows_reg    <= cfg_data;
                REG_IMAGE_COLS:    image_cols_reg    <= cfg_data;
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CH_W-1:0];
                REG_WINDOW_SIZE:   window_size_reg   <= cfg_data[WIN_W-1:0];
                REG_PASS_COUNT:    pass_count_reg    <= cfg_data[PASSCFG_W-1:0];
                REG_PASS_SHIFT:    pass_shift_reg    <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // output slot is empty once a restart has been taken, until its first pair is registered
    assign in_ready  = !first_pending_reg && (!out_valid_reg || out_ready);
    assign in_accept = in_valid && in_ready;
    assign launch    = in_accept && restart;
    assign step_fire = (in_accept && !restart) || (first_pending_reg && !setup_busy);

    always_comb
    begin
        first_pending_next = first_pending_reg;
        if (launch)
            first_pending_next = 1'b1;
        else if (first_pending_reg && !setup_busy)
            first_pending_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pending_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            first_pending_reg <= first_pending_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
            result_reg <= step_result;
    end

    mpwpag_setup u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .launch     (launch),
        .cfg_rows   (image_rows_reg),
        .cfg_cols   (image_cols_reg),
        .cfg_ch     (channel_count_reg),
        .cfg_win    (window_size_reg),
        .cfg_passes (pass_count_reg),
        .cfg_shift  (pass_shift_reg),
        .params     (params),
        .busy       (setup_busy),
        .start      (setup_start)
    );

    mpwpag_walker u_walker (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (launch),
        .start  (setup_start),
        .step   (step_fire),
        .params (params),
        .result (step_result)
    );

    assign out_valid      = out_valid_reg;
    assign pair_valid     = result_reg.pair_valid;
    assign source_address = result_reg.source_address;
    assign dest_address   = result_reg.dest_address;
    assign pass_number    = result_reg.pass_number;
    assign outside_image  = result_reg.outside_image;
    assign last_pair      = result_reg.last_pair;

    a_restart_empties_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && restart |=> !out_valid)
        else $error("output not empty after restart transaction");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !restart |=> out_valid)
        else $error("advance transaction produced no result");

    a_last_is_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_pair |-> pair_valid)
        else $error("last_pair without an address pair");

    a_outside_zero_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outside_image |-> source_address == '0)
        else $error("outside position carries a source address");

endmodule
